// ----- rtl/pct_pkg.sv -----
`default_nettype none

package pct_pkg;

  // Default build values for the top level parameters
  localparam int COORD_BITS_DEF = 20;
  localparam int MAX_POINTS_DEF = 4096;

  // Running shoelace sum width: twice the signed area, wraps modulo 2^64
  localparam int AREA_BITS = 64;

  // Per-vertex control that travels with the products down the pipe
  typedef struct packed {
    logic last;      // final vertex of the polygon
    logic en_edge;   // edge from the previous vertex to this one counts
    logic en_turn;   // turn at the previous vertex counts
    logic close;     // closing edge and both wrap-around turns count
    logic ovf;       // vertex count went past the limit
    logic short_n;   // fewer than three vertices
  } pct_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/polygon_concavity_test_core.sv -----
`default_nettype none

// Streaming polygon convexity test. Vertices of one closed polygon arrive one
// transaction at a time as signed X/Y coordinates, the final vertex marked by
// in_last_vertex; one result transaction follows each marked vertex, nothing
// follows the others. A new vertex is taken every cycle while in_stall is low.
// A final vertex passes through the input register, then the product register
// (ten signed multiplies of at most COORD_BITS+1 bits in parallel, the longest
// path in the block), then the result register, which also folds the products
// into the running shoelace sum and the turn flags. The result register frees
// the input side, so vertices keep flowing while a result waits to be taken;
// only a second final vertex that reaches the product register behind an
// untaken result holds the input, until that result is taken. A polygon is
// concave when some nonzero turn has the sign opposite to its area; fewer than
// three vertices or zero area report degenerate, and more than MAX_POINTS
// vertices report overflow only. The vertex count, running sum and turn flags
// return to zero after each final vertex, so the next polygon may start right
// behind it.
module polygon_concavity_test_core
  import pct_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output      logic                         in_stall,
  input  wire logic signed [COORD_BITS-1:0] in_x_coord,
  input  wire logic signed [COORD_BITS-1:0] in_y_coord,
  input  wire logic                         in_last_vertex,
  output      logic                         out_valid,
  input  wire logic                         out_stall,
  output      logic                         out_is_concave,
  output      logic                         out_degenerate,
  output      logic                         out_overflow
);

  // Count saturates at MAX_POINTS+1
  localparam int CNT_BITS = $clog2(MAX_POINTS + 2);
  // Coordinate difference, turn product, turn cross product
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int XW = PW + 1;
  // Shoelace product and edge term
  localparam int EW = 2 * COORD_BITS;
  localparam int TW = EW + 1;

  localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(MAX_POINTS);
  localparam logic [CNT_BITS-1:0] CNT_TWO = CNT_BITS'(2);
  localparam logic [CNT_BITS-1:0] CNT_ONE = CNT_BITS'(1);

  // ---------------------------------------------------------------------
  // Handshake and pipeline flow
  // ---------------------------------------------------------------------
  logic s1_v_r, s1_v_nxt;
  logic s2_v_r, s2_v_nxt;
  logic out_v_r, out_v_nxt;

  pct_ctl_t s1_ctl_r, s2_ctl_r, ctl_in;

  logic out_free, s2_ret, s2_room, s1_room, accept;

  // Output register frees up when empty or when its transaction is taken
  assign out_free = !out_v_r || !out_stall;
  // Non-final vertices retire from stage 2 without needing the output
  assign s2_ret   = s2_v_r && (!s2_ctl_r.last || out_free);
  assign s2_room  = !s2_v_r || s2_ret;
  assign s1_room  = !s1_v_r || s2_room;
  assign in_stall = !s1_room;
  assign accept   = in_valid && s1_room;

  // ---------------------------------------------------------------------
  // Vertex bookkeeping at accept: count, first two and last two points
  // ---------------------------------------------------------------------
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic signed [COORD_BITS-1:0] first_x_r, first_y_r, second_x_r, second_y_r;
  logic signed [COORD_BITS-1:0] older_x_r, older_y_r, recent_x_r, recent_y_r;

  always_comb begin
    ctl_in.last    = in_last_vertex;
    ctl_in.en_edge = (cnt_r != '0);
    ctl_in.en_turn = (cnt_r >= CNT_TWO);
    ctl_in.ovf     = (cnt_r >= CNT_MAX);
    ctl_in.short_n = (cnt_r < CNT_TWO);
    ctl_in.close   = in_last_vertex && (cnt_r >= CNT_TWO) && (cnt_r < CNT_MAX);
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      if (in_last_vertex) begin
        cnt_nxt = '0;
      end else if (cnt_r <= CNT_MAX) begin
        cnt_nxt = cnt_r + CNT_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (cnt_r == '0) begin
        first_x_r <= in_x_coord;
        first_y_r <= in_y_coord;
      end
      if (cnt_r == CNT_ONE) begin
        second_x_r <= in_x_coord;
        second_y_r <= in_y_coord;
      end
      older_x_r  <= recent_x_r;
      older_y_r  <= recent_y_r;
      recent_x_r <= in_x_coord;
      recent_y_r <= in_y_coord;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: snapshot of the vertex and the points its terms need
  // ---------------------------------------------------------------------
  logic signed [COORD_BITS-1:0] s1_x_r, s1_y_r, s1_ox_r, s1_oy_r;
  logic signed [COORD_BITS-1:0] s1_rx_r, s1_ry_r, s1_fx_r, s1_fy_r;
  logic signed [COORD_BITS-1:0] s1_sx_r, s1_sy_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl_r <= ctl_in;
      s1_x_r   <= in_x_coord;
      s1_y_r   <= in_y_coord;
      s1_ox_r  <= older_x_r;
      s1_oy_r  <= older_y_r;
      s1_rx_r  <= recent_x_r;
      s1_ry_r  <= recent_y_r;
      // On the first vertex its point is not yet in first_*
      s1_fx_r  <= (cnt_r == '0) ? in_x_coord : first_x_r;
      s1_fy_r  <= (cnt_r == '0) ? in_y_coord : first_y_r;
      s1_sx_r  <= second_x_r;
      s1_sy_r  <= second_y_r;
    end
  end

  // Turn A at the previous vertex (older, recent, x); turn B at this vertex
  // (recent, x, first); turn C at the first vertex (x, first, second).
  logic signed [DW-1:0] a1x, a1y, a2x, a2y;
  logic signed [DW-1:0] b2x, b2y, c2x, c2y;
  logic signed [PW-1:0] pa1, pa2, pb1, pb2, pc1, pc2;
  logic signed [EW-1:0] pe1, pe2, pf1, pf2;

  always_comb begin
    a1x = DW'(s1_rx_r) - DW'(s1_ox_r);
    a1y = DW'(s1_ry_r) - DW'(s1_oy_r);
    a2x = DW'(s1_x_r) - DW'(s1_rx_r);
    a2y = DW'(s1_y_r) - DW'(s1_ry_r);
    b2x = DW'(s1_fx_r) - DW'(s1_x_r);
    b2y = DW'(s1_fy_r) - DW'(s1_y_r);
    c2x = DW'(s1_sx_r) - DW'(s1_fx_r);
    c2y = DW'(s1_sy_r) - DW'(s1_fy_r);
    pa1 = PW'(a1x) * PW'(a2y);
    pa2 = PW'(a1y) * PW'(a2x);
    pb1 = PW'(a2x) * PW'(b2y);
    pb2 = PW'(a2y) * PW'(b2x);
    pc1 = PW'(b2x) * PW'(c2y);
    pc2 = PW'(b2y) * PW'(c2x);
    // Shoelace terms: edge recent->x and closing edge x->first
    pe1 = EW'(s1_rx_r) * EW'(s1_y_r);
    pe2 = EW'(s1_x_r) * EW'(s1_ry_r);
    pf1 = EW'(s1_x_r) * EW'(s1_fy_r);
    pf2 = EW'(s1_fx_r) * EW'(s1_y_r);
  end

  // ---------------------------------------------------------------------
  // Stage 2: registered products
  // ---------------------------------------------------------------------
  logic signed [PW-1:0] s2_pa1_r, s2_pa2_r, s2_pb1_r, s2_pb2_r, s2_pc1_r, s2_pc2_r;
  logic signed [EW-1:0] s2_pe1_r, s2_pe2_r, s2_pf1_r, s2_pf2_r;

  always_ff @(posedge clk) begin
    if (s1_v_r && s2_room) begin
      s2_ctl_r <= s1_ctl_r;
      s2_pa1_r <= pa1;
      s2_pa2_r <= pa2;
      s2_pb1_r <= pb1;
      s2_pb2_r <= pb2;
      s2_pc1_r <= pc1;
      s2_pc2_r <= pc2;
      s2_pe1_r <= pe1;
      s2_pe2_r <= pe2;
      s2_pf1_r <= pf1;
      s2_pf2_r <= pf2;
    end
  end

  // Fold into the running sum and flags; decide on the final vertex
  logic signed [XW-1:0] crs_a, crs_b, crs_c;
  logic signed [TW-1:0] edge_1, edge_2;
  logic [AREA_BITS-1:0] area_r, area_nxt, area_tot, d_1, d_2;
  logic left_r, left_nxt, right_r, right_nxt, left_all, right_all;
  logic pos_a, neg_a, pos_b, neg_b, pos_c, neg_c;
  logic res_cc_r, res_cc_nxt, res_dg_r, res_dg_nxt, res_of_r, res_of_nxt;

  always_comb begin
    crs_a  = XW'(s2_pa1_r) - XW'(s2_pa2_r);
    crs_b  = XW'(s2_pb1_r) - XW'(s2_pb2_r);
    crs_c  = XW'(s2_pc1_r) - XW'(s2_pc2_r);
    edge_1 = TW'(s2_pe1_r) - TW'(s2_pe2_r);
    edge_2 = TW'(s2_pf1_r) - TW'(s2_pf2_r);
    pos_a  = !crs_a[XW-1] && (crs_a != '0);
    neg_a  = crs_a[XW-1];
    pos_b  = !crs_b[XW-1] && (crs_b != '0);
    neg_b  = crs_b[XW-1];
    pos_c  = !crs_c[XW-1] && (crs_c != '0);
    neg_c  = crs_c[XW-1];
    d_1 = s2_ctl_r.en_edge ? AREA_BITS'(edge_1) : '0;
    d_2 = s2_ctl_r.close ? AREA_BITS'(edge_2) : '0;
    area_tot  = area_r + d_1 + d_2;
    left_all  = left_r || (s2_ctl_r.en_turn && pos_a) ||
                (s2_ctl_r.close && (pos_b || pos_c));
    right_all = right_r || (s2_ctl_r.en_turn && neg_a) ||
                (s2_ctl_r.close && (neg_b || neg_c));

    area_nxt   = area_r;
    left_nxt   = left_r;
    right_nxt  = right_r;
    res_cc_nxt = res_cc_r;
    res_dg_nxt = res_dg_r;
    res_of_nxt = res_of_r;
    if (s2_ret) begin
      if (s2_ctl_r.last) begin
        // Clear for the next polygon
        area_nxt   = '0;
        left_nxt   = 1'b0;
        right_nxt  = 1'b0;
        res_cc_nxt = 1'b0;
        res_dg_nxt = 1'b0;
        res_of_nxt = 1'b0;
        if (s2_ctl_r.ovf) begin
          res_of_nxt = 1'b1;
        end else if (s2_ctl_r.short_n) begin
          res_dg_nxt = 1'b1;
        end else if (area_tot == '0) begin
          res_dg_nxt = 1'b1;
        end else if (area_tot[AREA_BITS-1]) begin
          res_cc_nxt = left_all;
        end else begin
          res_cc_nxt = right_all;
        end
      end else begin
        area_nxt  = area_tot;
        left_nxt  = left_all;
        right_nxt = right_all;
      end
    end
  end

  always_comb begin
    s1_v_nxt  = s1_room ? in_valid : s1_v_r;
    s2_v_nxt  = s2_room ? s1_v_r : s2_v_r;
    out_v_nxt = out_free ? (s2_ret && s2_ctl_r.last) : out_v_r;
  end

  // ---------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      cnt_r   <= '0;
      area_r  <= '0;
      left_r  <= 1'b0;
      right_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
      cnt_r   <= cnt_nxt;
      area_r  <= area_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

  // Result register: hold while stalled
  always_ff @(posedge clk) begin
    res_cc_r <= res_cc_nxt;
    res_dg_r <= res_dg_nxt;
    res_of_r <= res_of_nxt;
  end

  assign out_valid      = out_v_r;
  assign out_is_concave = res_cc_r;
  assign out_degenerate = res_dg_r;
  assign out_overflow   = res_of_r;

`ifndef SYNTHESIS
  // A final vertex leaving stage 2 always lands in the result register
  a_final_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_ret && s2_ctl_r.last) |=> out_valid)
    else $error("final vertex retired without a result");

  // Concave and degenerate exclude each other
  a_cc_dg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_concave && out_degenerate))
    else $error("result both concave and degenerate");

  // Overflow reports alone
  a_ovf_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |-> (!out_is_concave && !out_degenerate))
    else $error("overflow result carries other flags");

  // A final vertex restarts the vertex count
  a_cnt_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last_vertex) |=> (cnt_r == '0))
    else $error("vertex count not cleared after final vertex");

  // The sums are clear right after a final vertex retires
  a_sum_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_ret && s2_ctl_r.last) |=> (area_r == '0 && !left_r && !right_r))
    else $error("running sums not cleared after final vertex");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/polygon_concavity_test_core_tb.sv -----
`timescale 1ns / 100ps

module polygon_concavity_test_core_tb
  import pct_pkg::*;
();

  localparam int CW      = COORD_BITS_DEF;
  localparam int MAX_PTS = MAX_POINTS_DEF;

  // Unit octagon in tenths; scaled and shifted it gives convex outlines
  localparam int OCT_X[8] = '{10, 7, 0, -7, -10, -7, 0, 7};
  localparam int OCT_Y[8] = '{0, 7, 10, 7, 0, -7, -10, -7};

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    logic is_concave;
    logic degenerate;
    logic overflow;
  } verdict_t;

  logic   clk            = 1'b0;
  logic   rst_n          = 1'b0;
  logic   in_valid       = 1'b0;
  logic   in_stall;
  coord_t in_x_coord     = '0;
  coord_t in_y_coord     = '0;
  logic   in_last_vertex = 1'b0;
  logic   out_valid;
  logic   out_stall      = 1'b0;
  logic   out_is_concave;
  logic   out_degenerate;
  logic   out_overflow;

  // Verdicts still owed by the block, oldest first
  verdict_t verdict_q[$];
  int       err_cnt   = 0;
  int       hold_left = 0;
  bit       calm      = 1'b0;   // when set, neither side idles

  // Outline being assembled for the next polygon
  coord_t outline_x[$];
  coord_t outline_y[$];

  // Geometry tracker: our own view of the polygon seen so far
  longint geo_first_x, geo_first_y, geo_second_x, geo_second_y;
  longint geo_older_x, geo_older_y, geo_recent_x, geo_recent_y;
  longint geo_area2;    // twice the signed area, wraps at 64 bits
  int     geo_count;    // stops one past MAX_PTS
  bit     geo_left, geo_right;

  polygon_concavity_test_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_x_coord     (in_x_coord),
    .in_y_coord     (in_y_coord),
    .in_last_vertex (in_last_vertex),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_is_concave (out_is_concave),
    .out_degenerate (out_degenerate),
    .out_overflow   (out_overflow)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hard stop in case the block hangs or loses a result
  initial begin
    #40_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic void clear_geometry();
    geo_first_x  = 0;
    geo_first_y  = 0;
    geo_second_x = 0;
    geo_second_y = 0;
    geo_older_x  = 0;
    geo_older_y  = 0;
    geo_recent_x = 0;
    geo_recent_y = 0;
    geo_area2    = 0;
    geo_count    = 0;
    geo_left     = 1'b0;
    geo_right    = 1'b0;
  endfunction

  // Record the sign of the turn a->b->c; a straight or reversed step counts as none
  function automatic void note_turn(longint ax, longint ay, longint bx, longint by,
                                    longint cx, longint cy);
    longint turn;
    turn = (bx - ax) * (cy - by) - (by - ay) * (cx - bx);
    if (turn > 0)
      geo_left = 1'b1;
    else if (turn < 0)
      geo_right = 1'b1;
  endfunction

  function automatic void add_edge(longint px, longint py, longint qx, longint qy);
    geo_area2 += px * qy - qx * py;
  endfunction

  // Fold one vertex into the tracker; return 1 with the verdict on the final vertex
  function automatic bit fold_vertex(coord_t xc, coord_t yc, logic last,
                                     output verdict_t v);
    longint x, y;
    x = xc;
    y = yc;
    v = '0;
    if (geo_count == 0) begin
      geo_first_x = x;
      geo_first_y = y;
    end else begin
      add_edge(geo_recent_x, geo_recent_y, x, y);
      if (geo_count == 1) begin
        geo_second_x = x;
        geo_second_y = y;
      end else begin
        note_turn(geo_older_x, geo_older_y, geo_recent_x, geo_recent_y, x, y);
      end
    end
    geo_older_x  = geo_recent_x;
    geo_older_y  = geo_recent_y;
    geo_recent_x = x;
    geo_recent_y = y;
    if (geo_count <= MAX_PTS)
      geo_count++;
    if (!last)
      return 1'b0;

    if (geo_count > MAX_PTS) begin
      v.overflow = 1'b1;
    end else if (geo_count < 3) begin
      v.degenerate = 1'b1;
    end else begin
      // close the ring: last edge back to the start, turns at last and first
      add_edge(x, y, geo_first_x, geo_first_y);
      note_turn(geo_older_x, geo_older_y, x, y, geo_first_x, geo_first_y);
      note_turn(x, y, geo_first_x, geo_first_y, geo_second_x, geo_second_y);
      if (geo_area2 == 0)
        v.degenerate = 1'b1;
      else if (geo_area2 > 0)
        v.is_concave = geo_right;
      else
        v.is_concave = geo_left;
    end
    clear_geometry();
    return 1'b1;
  endfunction

  // Send one vertex transaction. Valid stays high from one vertex to the next
  // unless a gap is drawn, so back-to-back transactions never toggle it.
  task automatic push_vertex(coord_t x, coord_t y, logic last);
    int       gap;
    verdict_t v;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_x_coord     <= x;
    in_y_coord     <= y;
    in_last_vertex <= last;
    do @(posedge clk); while (in_stall);
    if (fold_vertex(x, y, last, v))
      verdict_q.insert(verdict_q.size(), v);
  endtask

  task automatic add_point(longint x, longint y);
    outline_x.insert(outline_x.size(), x[CW-1:0]);
    outline_y.insert(outline_y.size(), y[CW-1:0]);
  endtask

  task automatic add_random_point();
    outline_x.insert(outline_x.size(), coord_t'($urandom()));
    outline_y.insert(outline_y.size(), coord_t'($urandom()));
  endtask

  // Send the assembled outline as one polygon, final vertex marked, then clear it
  task automatic send_outline();
    for (int i = 0; i < outline_x.size(); i++)
      push_vertex(outline_x[i], outline_y[i], i == outline_x.size() - 1);
    outline_x.delete();
    outline_y.delete();
  endtask

  // Hold the input side until every owed verdict has come back
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (verdict_q.size() != 0);
  endtask

  // Octagon subset in either winding; a dent pulls one vertex in to the center
  task automatic make_octagon(bit dent);
    int r, cx, cy, start, j, notch;
    bit rev;
    r     = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 100) : $urandom_range(1, 300000);
    cx    = $urandom_range(0, 400000) - 200000;
    cy    = $urandom_range(0, 400000) - 200000;
    start = $urandom_range(0, 7);
    rev   = $urandom_range(0, 1);
    for (int k = 0; k < 8; k++) begin
      j = rev ? (start + 8 - k) % 8 : (start + k) % 8;
      if ($urandom_range(0, 9) < 7)
        add_point(cx + r * OCT_X[j] / 10, cy + r * OCT_Y[j] / 10);
    end
    if (outline_x.size() < 3) begin
      outline_x.delete();
      outline_y.delete();
      for (int k = 0; k < 8; k++)
        add_point(cx + r * OCT_X[k] / 10, cy + r * OCT_Y[k] / 10);
    end
    if (dent) begin
      notch = $urandom_range(0, outline_x.size() - 1);
      outline_x[notch] = coord_t'(cx + $urandom_range(0, r / 10) - r / 20);
      outline_y[notch] = coord_t'(cy + $urandom_range(0, r / 10) - r / 20);
    end
  endtask

  // Points along one line: any such outline has zero area
  task automatic make_line();
    int n, cx, cy, dx, dy, t;
    n  = $urandom_range(3, 6);
    cx = $urandom_range(0, 400000) - 200000;
    cy = $urandom_range(0, 400000) - 200000;
    dx = $urandom_range(0, 2000) - 1000;
    dy = $urandom_range(0, 2000) - 1000;
    repeat (n) begin
      t = $urandom_range(0, 100);
      add_point(cx + t * dx, cy + t * dy);
    end
  endtask

  // Polygons of one and two vertices, at the coordinate extremes and at the origin
  task automatic test_short_polygons();
    add_point(-524288, -524288);
    send_outline();
    add_point(0, 0);
    send_outline();
    add_point(524287, 524287);
    add_point(-524288, 524287);
    send_outline();
  endtask

  // Convex and concave shapes in both windings, a flat one, a repeated vertex
  task automatic test_basic_shapes();
    add_point(0, 0);   add_point(10, 0);  add_point(10, 10); add_point(0, 10);
    send_outline();
    add_point(0, 10);  add_point(10, 10); add_point(10, 0);  add_point(0, 0);
    send_outline();
    add_point(0, 0);   add_point(4, 0);   add_point(2, 1);   add_point(4, 4);
    add_point(0, 4);
    send_outline();
    add_point(0, 4);   add_point(4, 4);   add_point(2, 1);   add_point(4, 0);
    add_point(0, 0);
    send_outline();
    add_point(0, 0);   add_point(1, 1);   add_point(2, 2);
    send_outline();
    add_point(-524288, -524288); add_point(524287, -524288); add_point(524287, 524287);
    send_outline();
    add_point(0, 0);   add_point(0, 0);   add_point(10, 0);  add_point(10, 10);
    send_outline();
  endtask

  // Vertex counts right at the limit and just past it, then a small polygon
  // to show the state came back clean after the overflow
  task automatic test_vertex_limit();
    int n;
    wait_results_drained();
    calm = 1'b1;
    for (int s = 0; s < 3; s++) begin
      n = MAX_PTS + ((s == 0) ? 0 : 2 * s - 1);
      repeat (n) add_random_point();
      send_outline();
    end
    add_point(0, 0); add_point(5, 0); add_point(0, 5);
    send_outline();
    calm = 1'b0;
  endtask

  // Mostly well-formed polygons with random size and placement, some noise
  task automatic test_random_polygons();
    int kind, sent;
    sent = 0;
    while (sent < 600) begin
      // toggle quiet stretches and drain now and then
      if ($urandom_range(0, 7) == 0)
        calm = !calm;
      if ($urandom_range(0, 19) == 0)
        wait_results_drained();
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        make_octagon(kind >= 45);
      end else if (kind < 85) begin
        repeat ($urandom_range(3, 10)) add_random_point();
      end else if (kind < 93) begin
        make_line();
      end else begin
        repeat ($urandom_range(1, 2)) add_random_point();
      end
      sent += outline_x.size();
      send_outline();
    end
    calm = 1'b0;
  endtask

  // Receiver: after each accepted result transaction, draw how long to stall
  always @(posedge clk) begin
    if (out_valid && !out_stall)
      hold_left = draw_gap();
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each accepted result transaction with the oldest owed verdict
  always @(posedge clk) begin : check_result
    verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: result with none owed: concave %0b degenerate %0b overflow %0b",
                 $realtime, out_is_concave, out_degenerate, out_overflow);
        err_cnt++;
      end else begin
        want = verdict_q.pop_front();
        if (out_is_concave !== want.is_concave) begin
          $display("%0t: is_concave expected %0b, got %0b",
                   $realtime, want.is_concave, out_is_concave);
          err_cnt++;
        end
        if (out_degenerate !== want.degenerate) begin
          $display("%0t: degenerate expected %0b, got %0b",
                   $realtime, want.degenerate, out_degenerate);
          err_cnt++;
        end
        if (out_overflow !== want.overflow) begin
          $display("%0t: overflow expected %0b, got %0b",
                   $realtime, want.overflow, out_overflow);
          err_cnt++;
        end
      end
    end
  end

  initial begin : main_seq
    int waited;
    clear_geometry();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_short_polygons();
    test_basic_shapes();
    test_vertex_limit();
    test_random_polygons();

    // Drop valid, let the owed verdicts come back, then allow the pipe to settle
    in_valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (verdict_q.size() != 0 && waited < 2000);
    if (verdict_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $realtime, verdict_q.size());
      err_cnt++;
    end
    repeat (10) @(posedge clk);

    if (err_cnt == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/pct_pkg.sv
rtl/polygon_concavity_test_core.sv
tb/sv/polygon_concavity_test_core_tb.sv
